FILE: design/vdu_stream_text_console_top_macros.svh
// Assertion helpers for the text console checker.
`ifndef VDU_STREAM_TEXT_CONSOLE_TOP_MACROS_SVH
`define VDU_STREAM_TEXT_CONSOLE_TOP_MACROS_SVH

// Clocked check, off while reset is high.
`define VDUSTC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset.
`define VDUSTC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/vdustc_pkg.sv
package vdustc_pkg;

  localparam int TEXT_COLUMNS = 58;
  localparam int TEXT_ROWS    = 40;
  localparam int MAX_RESULTS  = 4;

  typedef enum logic [2:0] {
    KIND_ECHO      = 3'd0,
    KIND_GLYPH     = 3'd1,
    KIND_ROW_CLEAR = 3'd2,
    KIND_PLOT      = 3'd3,
    KIND_UNSUP     = 3'd4
  } kind_t;

  // register select, taken from paddr[2]
  localparam logic REG_ECHO = 1'b0;
  localparam logic REG_DRAW = 1'b1;

  localparam logic [7:0] CH_LF      = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_PLOT    = 8'd25;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_P_UPPER = 8'h50;
  localparam logic [7:0] CH_P_LOWER = 8'h70;

  // total sequence length per control code, code byte included
  localparam logic [4:0] SEQ_LEN [32] = '{
    5'd1, 5'd2, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1,
    5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1,
    5'd1, 5'd2, 5'd3, 5'd6, 5'd1, 5'd1, 5'd2, 5'd21,
    5'd9, 5'd6, 5'd1, 5'd1, 5'd5, 5'd5, 5'd1, 5'd3
  };

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_byte;
    logic [5:0]  column;
    logic [5:0]  row;
    logic        colour;
    logic [7:0]  plot_type;
    logic [15:0] plot_x;
    logic [15:0] plot_y;
    logic        last;
  } res_t;

  typedef struct packed {
    res_t [MAX_RESULTS-1:0] slot;
    logic [2:0]             count;
  } batch_t;

  typedef struct packed {
    logic echo_en;
    logic draw_en;
  } cfg_t;

endpackage

FILE: design/vdustc_if.sv
interface vdustc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface vdustc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  out_byte;
  logic [5:0]  column;
  logic [5:0]  row;
  logic        colour;
  logic [7:0]  plot_type;
  logic [15:0] plot_x;
  logic [15:0] plot_y;
  logic        last;

  modport source (output valid, output kind, output out_byte, output column, output row,
                  output colour, output plot_type, output plot_x, output plot_y,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input column, input row,
                  input colour, input plot_type, input plot_x, input plot_y,
                  input last, output ready);
endinterface

FILE: design/vdu_stream_text_console_top.sv
// Text console front end: parses a byte stream of characters and VDU codes.
// in_stream  : one request per byte (in_byte). Printables, control codes and
//              their parameter bytes all arrive here.
// out_stream : result requests (kind, out_byte, column, row, colour,
//              plot_type, plot_x, plot_y, last). last marks the final result
//              caused by one input byte; a byte may cause none at all.
// APB port   : 0x0 echo_enable, 0x4 draw_enable, bit 0 of the data word.
//              pready is tied high; write only while the stream is idle.
// Path       : each result is registered in the result buffer and then in
//              the output register before it shows on out_stream.
// Throughput : one result per cycle on the output while out_stream ready is
//              high. A byte causing k results holds the input while the
//              four-entry result buffer drains through the single output
//              port; k is at most four (plot request, echo, row clear, glyph).
// Reset      : rst clears cursor, pending sequence and the result path;
//              echo comes up on, draw off. Parameter bytes are not cleared.
// Stall      : a result held on out_stream with ready low stays put; if the
//              buffer behind it is empty it takes one more byte's results,
//              then input ready drops until the output moves again.
module vdu_stream_text_console_top (
  input  logic         clk,
  input  logic         rst,
  vdustc_in_if.sink    in_stream,
  vdustc_out_if.source out_stream,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  vdustc_pkg::cfg_t   cfg;
  vdustc_pkg::batch_t batch;
  logic               acc;
  logic               in_ready;

  assign acc             = in_stream.valid && in_ready;
  assign in_stream.ready = in_ready;

  // configuration registers
  vdustc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // cursor / sequence state and the per-byte result list
  vdustc_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .acc     (acc),
    .in_byte (in_stream.in_byte),
    .cfg     (cfg),
    .batch   (batch)
  );

  // result buffer plus output register
  vdustc_resq u_resq (
    .clk        (clk),
    .rst        (rst),
    .load       (acc),
    .batch      (batch),
    .in_ready   (in_ready),
    .out_stream (out_stream)
  );

endmodule

FILE: design/vdustc_cfg.sv
module vdustc_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output vdustc_pkg::cfg_t  cfg
);

  logic echo_en;
  logic draw_en;
  logic wr;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_en <= 1'b1;
      draw_en <= 1'b0;
    end else if (wr) begin
      if (paddr[2] == vdustc_pkg::REG_ECHO) begin
        echo_en <= pwdata[0];
      end else begin
        draw_en <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == vdustc_pkg::REG_DRAW) begin
      prdata = {31'd0, draw_en};
    end else begin
      prdata = {31'd0, echo_en};
    end
  end

  assign cfg.echo_en = echo_en;
  assign cfg.draw_en = draw_en;

endmodule

FILE: design/vdustc_parser.sv
module vdustc_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                acc,
  input  logic [7:0]          in_byte,
  input  vdustc_pkg::cfg_t    cfg,
  output vdustc_pkg::batch_t  batch
);

  logic [4:0] pend_cnt;
  logic [4:0] pend_code;
  logic [5:0] cur_col;
  logic [5:0] cur_row;
  logic [7:0] param [4];

  logic [4:0] pend_cnt_next;
  logic [4:0] pend_code_next;
  logic [5:0] cur_col_next;
  logic [5:0] cur_row_next;
  logic [4:0] pm1;
  logic       param_we;
  logic [1:0] param_idx;

  // first four parameter bytes are stored; the fifth is the byte that
  // completes a plot, so it is taken straight from the input
  assign pm1       = pend_cnt - 5'd1;
  assign param_we  = (pend_cnt != 5'd0) && (pm1 < 5'd4);
  assign param_idx = pm1[1:0];

  always_comb begin
    logic               check;
    logic               do_put;
    logic               plot;
    logic               unsup;
    logic [7:0]         put_ch;
    logic [6:0]         row_inc;
    logic [2:0]         n;
    vdustc_pkg::res_t   r;
    vdustc_pkg::batch_t b;

    pend_cnt_next  = pend_cnt;
    pend_code_next = pend_code;
    cur_col_next   = cur_col;
    cur_row_next   = cur_row;
    check   = 1'b0;
    do_put  = 1'b0;
    plot    = 1'b0;
    unsup   = 1'b0;
    row_inc = '0;
    n       = '0;
    r       = '0;
    b       = '0;

    if (pend_cnt != 5'd0) begin
      pend_cnt_next = pend_cnt + 5'd1;
      check = 1'b1;
    end else if (in_byte < vdustc_pkg::CH_SPACE) begin
      pend_code_next = in_byte[4:0];
      pend_cnt_next  = 5'd1;
      check = 1'b1;
    end else begin
      do_put = 1'b1;
    end

    if (check && (pend_cnt_next == vdustc_pkg::SEQ_LEN[pend_code_next])) begin
      pend_cnt_next = 5'd0;
      if (pend_code_next == vdustc_pkg::CH_LF[4:0] ||
          pend_code_next == vdustc_pkg::CH_CR[4:0]) begin
        do_put = 1'b1;
      end else if (pend_code_next == vdustc_pkg::CH_PLOT[4:0]) begin
        plot   = 1'b1;
        do_put = 1'b1;
      end else begin
        unsup = 1'b1;
      end
    end

    put_ch = plot ? vdustc_pkg::CH_P_UPPER : in_byte;

    if (plot) begin
      r           = '0;
      r.kind      = vdustc_pkg::KIND_PLOT;
      r.plot_type = param[0];
      r.plot_x    = {param[2], param[1]};
      r.plot_y    = {in_byte, param[3]};
      b.slot[n[1:0]] = r;
      n = n + 3'd1;
    end

    if (unsup) begin
      r          = '0;
      r.kind     = vdustc_pkg::KIND_UNSUP;
      r.out_byte = {3'd0, pend_code_next};
      b.slot[n[1:0]] = r;
      n = n + 3'd1;
    end

    if (do_put) begin
      if (cfg.echo_en) begin
        r          = '0;
        r.kind     = vdustc_pkg::KIND_ECHO;
        r.out_byte = put_ch;
        b.slot[n[1:0]] = r;
        n = n + 3'd1;
      end
      if (cur_col_next >= 6'(vdustc_pkg::TEXT_COLUMNS) || put_ch == vdustc_pkg::CH_LF) begin
        cur_col_next = 6'd0;
        row_inc      = {1'b0, cur_row_next} + 7'd1;
        cur_row_next = (row_inc >= 7'(vdustc_pkg::TEXT_ROWS)) ? 6'd0 : row_inc[5:0];
        r      = '0;
        r.kind = vdustc_pkg::KIND_ROW_CLEAR;
        r.row  = cur_row_next;
        b.slot[n[1:0]] = r;
        n = n + 3'd1;
      end
      if (put_ch == vdustc_pkg::CH_CR) begin
        cur_col_next = 6'd0;
      end
      if (put_ch != vdustc_pkg::CH_LF && put_ch != vdustc_pkg::CH_CR) begin
        if (cfg.draw_en) begin
          r          = '0;
          r.kind     = vdustc_pkg::KIND_GLYPH;
          r.out_byte = plot ? vdustc_pkg::CH_P_LOWER : put_ch;
          r.column   = cur_col_next;
          r.row      = cur_row_next;
          r.colour   = plot;
          b.slot[n[1:0]] = r;
          n = n + 3'd1;
        end
        cur_col_next = cur_col_next + 6'd1;
      end
    end

    if (n != 3'd0) begin
      b.slot[n[1:0] - 2'd1].last = 1'b1;
    end
    b.count = n;
    batch   = b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cnt  <= '0;
      pend_code <= '0;
      cur_col   <= '0;
      cur_row   <= '0;
    end else if (acc) begin
      pend_cnt  <= pend_cnt_next;
      pend_code <= pend_code_next;
      cur_col   <= cur_col_next;
      cur_row   <= cur_row_next;
    end
  end

  // parameter bytes: no reset, only read once written
  always_ff @(posedge clk) begin
    if (acc && param_we) begin
      param[param_idx] <= in_byte;
    end
  end

endmodule

FILE: design/vdustc_resq.sv
module vdustc_resq (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  vdustc_pkg::batch_t  batch,
  output logic                in_ready,
  vdustc_out_if.source        out_stream
);

  vdustc_pkg::res_t [vdustc_pkg::MAX_RESULTS-1:0] slots;
  logic [2:0]       cnt;
  vdustc_pkg::res_t oreg;
  logic             ovalid;
  logic             move;

  assign move     = (cnt != 3'd0) && (!ovalid || out_stream.ready);
  assign in_ready = !rst && ((cnt == 3'd0) || (cnt == 3'd1 && move));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      ovalid <= 1'b0;
    end else begin
      if (move) begin
        ovalid <= 1'b1;
      end else if (out_stream.ready) begin
        ovalid <= 1'b0;
      end
      if (load) begin
        cnt <= batch.count;
      end else if (move) begin
        cnt <= cnt - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      oreg <= slots[0];
    end
    if (load) begin
      slots <= batch.slot;
    end else if (move) begin
      for (int i = 0; i < vdustc_pkg::MAX_RESULTS - 1; i++) begin
        slots[i] <= slots[i+1];
      end
      slots[vdustc_pkg::MAX_RESULTS-1] <= '0;
    end
  end

  assign out_stream.valid     = ovalid;
  assign out_stream.kind      = oreg.kind;
  assign out_stream.out_byte  = oreg.out_byte;
  assign out_stream.column    = oreg.column;
  assign out_stream.row       = oreg.row;
  assign out_stream.colour    = oreg.colour;
  assign out_stream.plot_type = oreg.plot_type;
  assign out_stream.plot_x    = oreg.plot_x;
  assign out_stream.plot_y    = oreg.plot_y;
  assign out_stream.last      = oreg.last;

endmodule

FILE: design/vdustc_checker.sv
`include "vdu_stream_text_console_top_macros.svh"

module vdustc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [5:0]  out_column,
  input logic [5:0]  out_row,
  input logic [7:0]  out_plot_type,
  input logic [15:0] out_plot_x,
  input logic [15:0] out_plot_y
);

  `VDUSTC_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid, "result valid after reset")

  `VDUSTC_ASSERT(a_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_kind), "stalled result dropped")

  `VDUSTC_ASSERT(a_glyph_pos, clk, rst, out_valid && out_kind == vdustc_pkg::KIND_GLYPH |-> out_column < 6'(vdustc_pkg::TEXT_COLUMNS) && out_row < 6'(vdustc_pkg::TEXT_ROWS), "glyph off screen")

  `VDUSTC_ASSERT(a_plot_zero, clk, rst, out_valid && out_kind != vdustc_pkg::KIND_PLOT |-> out_plot_type == 8'd0 && out_plot_x == 16'd0 && out_plot_y == 16'd0, "plot fields set on non-plot result")

endmodule

bind vdu_stream_text_console_top vdustc_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_stream.valid),
  .out_ready     (out_stream.ready),
  .out_kind      (out_stream.kind),
  .out_column    (out_stream.column),
  .out_row       (out_stream.row),
  .out_plot_type (out_stream.plot_type),
  .out_plot_x    (out_stream.plot_x),
  .out_plot_y    (out_stream.plot_y)
);
